// File: rtl/bfs_pkg.sv
// shared types, register codes and mark helpers for the byte frame sync block
// no dependencies
package bfs_pkg;

  localparam int MAX_MARK_LEN = 4;
  localparam int MARK_BYTES   = 4;

  typedef enum logic [1:0] {
    PHASE_HEADER  = 2'd0,
    PHASE_PAYLOAD = 2'd1,
    PHASE_TRAILER = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_HEADER_LEN    = 3'd0,
    REG_HEADER_BYTES  = 3'd1,
    REG_PAYLOAD_LEN   = 3'd2,
    REG_TRAILER_LEN   = 3'd3,
    REG_TRAILER_BYTES = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [2:0]  header_len;
    logic [31:0] header_bytes;
    logic [7:0]  payload_len;
    logic [2:0]  trailer_len;
    logic [31:0] trailer_bytes;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] position;
  } sync_state_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_index;
    logic [7:0] payload_byte;
    logic       frame_ok;
  } result_t;

  // mark length clipped to the supported maximum
  function automatic logic [7:0] mark_len(input logic [2:0] len);
    logic [7:0] wide;
    wide = {5'd0, len};
    if (wide > 8'(MAX_MARK_LEN)) begin
      return 8'(MAX_MARK_LEN);
    end
    return wide;
  endfunction

  // byte idx of a packed mark, zero past the packed bytes
  function automatic logic [7:0] mark_byte(input logic [31:0] marks, input logic [7:0] idx);
    logic [7:0] r;
    r = '0;
    if (idx < 8'(MARK_BYTES) && idx < 8'(MAX_MARK_LEN)) begin
      r = marks[{idx[1:0], 3'b000} +: 8];
    end
    return r;
  endfunction

endpackage

// File: rtl/bfs_step.sv
// next-state and result logic for one received byte
// depends on bfs_pkg
module bfs_step import bfs_pkg::*; (
  input  cfg_t        cfg,
  input  sync_state_t cur,
  input  logic [7:0]  rx_byte,
  output sync_state_t nxt,
  output result_t     res
);

  logic [7:0] pos_inc;
  logic [7:0] plen;
  logic [7:0] hlen;
  logic [7:0] tlen;
  logic       hdr_hit;
  logic       trl_hit;

  assign pos_inc = cur.position + 8'd1;
  assign plen    = (cfg.payload_len == 8'd0) ? 8'd1 : cfg.payload_len;
  assign hlen    = mark_len((cfg.header_len == 3'd0) ? 3'd1 : cfg.header_len);
  assign tlen    = mark_len(cfg.trailer_len);
  assign hdr_hit = (rx_byte == mark_byte(cfg.header_bytes, cur.position));
  assign trl_hit = (rx_byte == mark_byte(cfg.trailer_bytes, cur.position));

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PHASE_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_index = cur.position;
        res.payload_byte  = rx_byte;
        nxt.position      = pos_inc;
        if (pos_inc == 8'd0 || pos_inc >= plen) begin
          nxt.position = '0;
          if (cfg.trailer_len == 3'd0) begin
            nxt.phase    = PHASE_HEADER;
            res.frame_ok = 1'b1;
          end else begin
            nxt.phase = PHASE_TRAILER;
          end
        end
      end
      PHASE_TRAILER: begin
        nxt.position = pos_inc;
        if (!trl_hit) begin
          nxt.phase    = PHASE_HEADER;
          nxt.position = '0;
        end else if (pos_inc >= tlen) begin
          nxt.phase    = PHASE_HEADER;
          nxt.position = '0;
          res.frame_ok = 1'b1;
        end
      end
      default: begin
        // header hunt, also the unused phase code
        nxt.phase    = PHASE_HEADER;
        nxt.position = pos_inc;
        if (!hdr_hit) begin
          nxt.position = '0;
        end else if (pos_inc >= hlen) begin
          nxt.phase    = PHASE_PAYLOAD;
          nxt.position = '0;
        end
      end
    endcase
  end

endmodule

// File: rtl/byte_frame_sync_header_trailer_core.sv
// top level of the byte frame synchronizer: config registers, sync state, result register
// depends on bfs_pkg and bfs_step
//
// byte-stream frame synchronizer. every received byte (rx_byte) is one input
// transaction and yields exactly one result transaction. the block hunts for a
// header of header_len bytes (1 to 4, byte i of header_bytes in bits 8i+7..8i);
// a mismatching byte restarts the hunt and is not retried as a first header byte.
// after the header, payload_len bytes come out with payload_valid set and their
// index in payload_index; other results carry zero payload fields. if
// trailer_len is nonzero the trailer bytes are then checked, and a mismatch
// returns to hunting without a frame. frame_ok marks the byte that completes a
// frame (the last payload byte when there is no trailer). throughput is one byte
// per clock while out_ready stays high: the phase/position update is a single
// compare and increment feeding the state register, and the result register is
// refilled in the same cycle it is drained. configuration writes are always
// accepted (cfg_ready is tied high) and take effect on the next byte; write them
// only while the block is idle.
module byte_frame_sync_header_trailer_core import bfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // received byte channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        payload_valid,
  output logic [7:0]  payload_index,
  output logic [7:0]  payload_byte,
  output logic        frame_ok
);

  cfg_t        cfg_regs;
  sync_state_t sync_state;
  sync_state_t sync_state_next;
  result_t     step_res;
  result_t     result;
  logic        in_fire;

  // config writes never stall
  assign cfg_ready = 1'b1;

  // take a new byte whenever the result register is empty or being drained
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.header_len    <= 3'd2;
      cfg_regs.header_bytes  <= '0;
      cfg_regs.payload_len   <= 8'd1;
      cfg_regs.trailer_len   <= '0;
      cfg_regs.trailer_bytes <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER_LEN:    cfg_regs.header_len    <= cfg_data[2:0];
        REG_HEADER_BYTES:  cfg_regs.header_bytes  <= cfg_data;
        REG_PAYLOAD_LEN:   cfg_regs.payload_len   <= cfg_data[7:0];
        REG_TRAILER_LEN:   cfg_regs.trailer_len   <= cfg_data[2:0];
        REG_TRAILER_BYTES: cfg_regs.trailer_bytes <= cfg_data;
        default: ; // indexes past the register list are dropped
      endcase
    end
  end

  // phase and position decision for the incoming byte
  bfs_step u_step (
    .cfg     (cfg_regs),
    .cur     (sync_state),
    .rx_byte (rx_byte),
    .nxt     (sync_state_next),
    .res     (step_res)
  );

  // sync state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_state.phase    <= PHASE_HEADER;
      sync_state.position <= '0;
    end else if (in_fire) begin
      sync_state <= sync_state_next;
    end
  end

  // result register, valid flag under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= step_res;
    end
  end

  assign payload_valid = result.payload_valid;
  assign payload_index = result.payload_index;
  assign payload_byte  = result.payload_byte;
  assign frame_ok      = result.frame_ok;

endmodule

// File: rtl/bfs_checker.sv
// port-level checks for the byte frame synchronizer, bound to the top level
// no package dependencies
module bfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [7:0]  payload_index,
  input logic [7:0]  payload_byte,
  input logic        frame_ok
);

  logic       prev_pv;
  logic [7:0] prev_idx;

  // last delivered result's payload position
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pv  <= 1'b0;
      prev_idx <= '0;
    end else if (out_valid && out_ready) begin
      prev_pv  <= payload_valid;
      prev_idx <= payload_index;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(payload_valid) &&
      $stable(payload_index) && $stable(payload_byte) && $stable(frame_ok))
    else $error("result changed while stalled");

  // an accepted byte always shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  // empty result register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // non-payload results carry zero payload fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> payload_index == 8'd0 && payload_byte == 8'd0)
    else $error("payload fields set on a non-payload result");

  // payload indexes count up one per delivered result
  a_index_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && payload_valid && payload_index != 8'd0 |->
      prev_pv && 8'(prev_idx + 8'd1) == payload_index)
    else $error("payload index out of sequence");

endmodule

bind byte_frame_sync_header_trailer_core bfs_checker u_bfs_checker (.*);

// File: test/tb_byte_frame_sync_header_trailer_core.sv
// self-checking testbench for byte_frame_sync_header_trailer_core
// predicts every result transaction with its own model of the header/payload/trailer sync
// depends on bfs_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_byte_frame_sync_header_trailer_core;
  import bfs_pkg::*;

  localparam int         HOLD_CYCLES    = 64;       // long receiver hold-off to back up the core
  localparam int         RUN_LIMIT_NS   = 400_000;  // far past the slowest run
  localparam int         MAX_REPORTS    = 10;
  localparam logic [2:0] REG_LAST_INDEX = 3'd7;     // top of the 3-bit index space

  // sync tracker: config copy, phase/position state and the results still due
  class frame_sync_tracker;
    logic [2:0]  header_len;
    logic [31:0] header_bytes;
    logic [7:0]  payload_len;
    logic [2:0]  trailer_len;
    logic [31:0] trailer_bytes;
    phase_t      phase;
    logic [7:0]  position;
    result_t     results_due[$];
    int          failures;

    function new();
      header_len    = 3'd2;
      header_bytes  = '0;
      payload_len   = 8'd1;
      trailer_len   = 3'd0;
      trailer_bytes = '0;
      phase         = PHASE_HEADER;
      position      = '0;
      failures      = 0;
    endfunction

    // lengths above the supported mark size are clipped
    function int mark_count(logic [2:0] len);
      return (len > 3'(MAX_MARK_LEN)) ? MAX_MARK_LEN : int'(len);
    endfunction

    // byte idx of a packed mark, zero past the packed bytes
    function logic [7:0] mark_at(logic [31:0] marks, logic [7:0] idx);
      if (idx >= 8'(MARK_BYTES) || idx >= 8'(MAX_MARK_LEN)) return 8'd0;
      return marks[8 * int'(idx) +: 8];
    endfunction

    // register write; indexes past the list are dropped
    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_HEADER_LEN:    header_len    = data[2:0];
        REG_HEADER_BYTES:  header_bytes  = data;
        REG_PAYLOAD_LEN:   payload_len   = data[7:0];
        REG_TRAILER_LEN:   trailer_len   = data[2:0];
        REG_TRAILER_BYTES: trailer_bytes = data;
        default: ;
      endcase
    endfunction

    // one accepted rx byte: advance the sync state and queue its result
    function void take_rx_byte(logic [7:0] b);
      result_t r;
      int      plen;
      int      hlen;
      int      tlen;
      logic    hit;
      r = '0;
      case (phase)
        PHASE_PAYLOAD: begin
          plen = (payload_len == 8'd0) ? 1 : int'(payload_len);
          r.payload_valid = 1'b1;
          r.payload_index = position;
          r.payload_byte  = b;
          position = position + 8'd1;
          // wrap or reaching the (possibly lowered) length ends the payload
          if (position == 8'd0 || int'(position) >= plen) begin
            position = '0;
            if (trailer_len == 3'd0) begin
              phase      = PHASE_HEADER;
              r.frame_ok = 1'b1;
            end else begin
              phase = PHASE_TRAILER;
            end
          end
        end
        PHASE_TRAILER: begin
          tlen = mark_count(trailer_len);
          hit  = (b == mark_at(trailer_bytes, position));
          position = position + 8'd1;
          if (!hit) begin
            phase    = PHASE_HEADER;
            position = '0;
          end else if (int'(position) >= tlen) begin
            phase      = PHASE_HEADER;
            position   = '0;
            r.frame_ok = 1'b1;
          end
        end
        default: begin
          // header hunt; a zero length counts as one byte
          hlen = mark_count((header_len == 3'd0) ? 3'd1 : header_len);
          hit  = (b == mark_at(header_bytes, position));
          phase    = PHASE_HEADER;
          position = position + 8'd1;
          if (!hit) begin
            position = '0;
          end else if (int'(position) >= hlen) begin
            phase    = PHASE_PAYLOAD;
            position = '0;
          end
        end
      endcase
      results_due.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: valid=%0d index=%0d byte=%02h ok=%0d",
                   got.payload_valid, got.payload_index, got.payload_byte, got.frame_ok);
        return;
      end
      want = results_due.pop_front();
      if (got.payload_valid !== want.payload_valid || got.payload_index !== want.payload_index ||
          got.payload_byte !== want.payload_byte || got.frame_ok !== want.frame_ok) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display({"mismatch: expected valid=%0d index=%0d byte=%02h ok=%0d,",
                    " got valid=%0d index=%0d byte=%02h ok=%0d"},
                   want.payload_valid, want.payload_index, want.payload_byte, want.frame_ok,
                   got.payload_valid, got.payload_index, got.payload_byte, got.frame_ok);
      end
    endfunction
  endclass

  // clock, reset and every core input start at a known value
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        payload_valid;
  logic [7:0]  payload_index;
  logic [7:0]  payload_byte;
  logic        frame_ok;

  frame_sync_tracker tracker;

  // idling knobs, percent of cycles, set per phase by the stimulus
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int bytes_sent     = 0;

  // hold-off requests from the stimulus, served by the receiver process
  int hold_asked   = 0;
  int hold_granted = 0;
  int hold_left    = 0;

  byte_frame_sync_header_trailer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .payload_valid (payload_valid),
    .payload_index (payload_index),
    .payload_byte  (payload_byte),
    .frame_ok      (frame_ok)
  );

  always #2 clk = ~clk;

  // receiver: checks each result transaction and drives out_ready
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tracker.check_result({payload_valid, payload_index, payload_byte, frame_ok});
      if (hold_left > 0) begin
        // long hold-off in progress, the core has to stall its input
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_granted != hold_asked) begin
        hold_granted <= hold_asked;
        hold_left    <= HOLD_CYCLES;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit, independent of the stimulus
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_byte_frame_sync_header_trailer_core NOT OK");
    $finish;
  end

  // one rx byte transaction; valid stays up across back-to-back bytes
  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_rx_byte(b);
    bytes_sent++;
  endtask

  // one register write transaction; the caller lowers cfg_valid after a burst
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_settings(input logic [2:0] hl, input logic [31:0] hb,
                               input logic [7:0] pl, input logic [2:0] tl,
                               input logic [31:0] tb);
    write_reg(REG_HEADER_LEN,    {29'd0, hl});
    write_reg(REG_HEADER_BYTES,  hb);
    write_reg(REG_PAYLOAD_LEN,   {24'd0, pl});
    write_reg(REG_TRAILER_LEN,   {29'd0, tl});
    write_reg(REG_TRAILER_BYTES, tb);
    cfg_valid <= 1'b0;
  endtask

  // wait for every due result, then let the result register settle
  task automatic drain();
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // a frame under the current settings, sometimes with noise ahead,
  // a header cut short by a wrong byte or a corrupted trailer byte
  task automatic send_frame();
    int hlen;
    int plen;
    int tlen;
    int cut;
    int bad_at;
    logic [7:0] b;
    hlen = tracker.mark_count((tracker.header_len == 3'd0) ? 3'd1 : tracker.header_len);
    plen = (tracker.payload_len == 8'd0) ? 1 : int'(tracker.payload_len);
    tlen = tracker.mark_count(tracker.trailer_len);
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
    cut = ($urandom_range(99) < 12) ? int'($urandom_range(hlen - 1)) : hlen;
    for (int i = 0; i < hlen; i++) begin
      b = tracker.mark_at(tracker.header_bytes, 8'(i));
      if (i == cut) begin
        send_byte(b ^ 8'($urandom_range(1, 255)));
        return;
      end
      send_byte(b);
    end
    repeat (plen) send_byte(8'($urandom));
    bad_at = (tlen > 0 && $urandom_range(99) < 15) ? int'($urandom_range(tlen - 1)) : -1;
    for (int i = 0; i < tlen; i++) begin
      b = tracker.mark_at(tracker.trailer_bytes, 8'(i));
      send_byte((i == bad_at) ? (b ^ 8'($urandom_range(1, 255))) : b);
    end
  endtask

  // random frames until the byte budget is used, then drain
  task automatic run_phase(input int budget, input int send_pct, input int recv_pct);
    int stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) send_frame();
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    // reset settings: header 00 00, one payload byte, no trailer;
    // a mismatch at the second header byte is not retried as a first byte
    logic [7:0] reset_seq [12] = '{8'hFF, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h80,
                                   8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00};
    // header length zero (one byte A5), payload length zero, trailer length
    // saturated to four: good frame, then a trailer mismatch
    logic [7:0] short_seq [10] = '{8'hA5, 8'h3C, 8'h01, 8'h02, 8'h03, 8'h04,
                                   8'hA5, 8'hC3, 8'h01, 8'h09};
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_seq[i]) send_byte(reset_seq[i]);
    in_valid <= 1'b0;
    drain();

    load_settings(3'd0, 32'h0000_00A5, 8'd0, 3'd7, 32'h0403_0201);
    foreach (short_seq[i]) send_byte(short_seq[i]);
    in_valid <= 1'b0;
    drain();

    // longest marks and payload, no idling, one long receiver hold-off
    load_settings(3'd4, $urandom, 8'd255, 3'd4, $urandom);
    hold_asked++;
    run_phase(200, 0, 0);

    // writes past the register list must leave the settings alone
    for (int r = int'(REG_TRAILER_BYTES) + 1; r <= int'(REG_LAST_INDEX); r++)
      write_reg(3'(r), $urandom);
    cfg_valid <= 1'b0;

    // shortest frame: one header byte, one payload byte
    load_settings(3'd1, $urandom, 8'd1, 3'd0, 32'hFFFF_FFFF);
    run_phase(150, 51, 0);

    // oversized lengths saturate, zero payload length acts as one
    load_settings(3'd7, 32'hFFFF_FFFF, 8'd0, 3'd5, 32'h0000_0000);
    run_phase(120, 0, 51);

    // random settings, short payloads
    load_settings(3'($urandom_range(7)), $urandom, 8'($urandom_range(1, 12)),
                  3'($urandom_range(7)), $urandom);
    run_phase(110, 38, 38);

    load_settings(3'($urandom_range(7)), $urandom, 8'($urandom_range(1, 12)),
                  3'($urandom_range(7)), $urandom);
    hold_asked++;
    run_phase(110, 0, 0);

    load_settings(3'($urandom_range(7)), $urandom, 8'($urandom_range(1, 12)),
                  3'($urandom_range(7)), $urandom);
    run_phase(110, 38, 38);

    if (tracker.failures == 0 && tracker.results_due.size() == 0)
      $display("tb_byte_frame_sync_header_trailer_core OK");
    else
      $display("tb_byte_frame_sync_header_trailer_core NOT OK");
    $finish;
  end

endmodule

// File: sim.f
rtl/bfs_pkg.sv
rtl/bfs_step.sv
rtl/byte_frame_sync_header_trailer_core.sv
rtl/bfs_checker.sv
test/tb_byte_frame_sync_header_trailer_core.sv
